/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the top design file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/tra_pkg.sv */
// ----------------------------------------------------------------------------
// tra_pkg
// types and codes of the temp register spill allocator
// ----------------------------------------------------------------------------
package tra_pkg;

   localparam logic [1:0] CMD_ACQUIRE = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_NOTE    = 2'd2;
   localparam logic [1:0] CMD_RESTART = 2'd3;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_NOT_HELD = 2'd2;

   localparam logic [3:0] WIDE_WORD_BYTES   = 4'd8;
   localparam logic [3:0] NARROW_WORD_BYTES = 4'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_FINISH,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [15:0]        temp_id;
      logic signed [15:0] local_offset;
   } req_payload_type;

   typedef struct packed {
      logic               in_register;
      logic [2:0]         register_index;
      logic signed [15:0] frame_offset;
      logic [3:0]         slot_bytes;
      logic               grew_stack;
      logic [1:0]         status;
   } rsp_payload_type;

endpackage

/* design/tra_chan_if.sv */
// ----------------------------------------------------------------------------
// tra_chan_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface tra_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* design/temp_register_spill_allocator.sv */
// ----------------------------------------------------------------------------
// temp_register_spill_allocator
// maps temporary ids to machine registers or spilled frame slots
// ----------------------------------------------------------------------------
//   channel   dir   handshake        payload
//   req_bus   in    valid / ready    command, temp_id, local_offset
//   rsp_bus   out   valid / ready    in_register .. status, one beat per req
//   csr_*     in    csr_wr_en        word_bytes
//
// note, restart and id zero: no table scan, straight from idle to reply
// acquire / release: a read state and a check state per scanned entry, plus a finish
//   state when no entry holds the id; entries are read one by one through the one owner ram read port
// reset clears per-slot valid bits at once, no clearing pass
// a result waiting in the output register does not hold off the next req beat

`include "assert_macros.svh"

module temp_register_spill_allocator #(
   parameter int MAX_SLOTS      = 32,
   parameter int REGISTER_SLOTS = 5,
   parameter int ID_BITS        = 16
) (
   input  logic       clock,
   input  logic       reset,
   tra_chan_if.sink   req_bus,
   tra_chan_if.source rsp_bus,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);
   localparam int SlotW = $clog2(MAX_SLOTS);

   logic               mem_rd_en;
   logic [SlotW-1:0]   mem_rd_addr;
   logic [SlotW-1:0]   mem_wr_addr;
   logic               owner_wr_en;
   logic [ID_BITS-1:0] owner_wr_data;
   logic [ID_BITS-1:0] owner_rd_data;
   logic               offset_wr_en;
   logic [15:0]        offset_wr_data;
   logic [15:0]        offset_rd_data;

   tra_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (MAX_SLOTS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (owner_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (owner_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (owner_rd_data)
   );

   tra_ram #(
      .WIDTH (16),
      .DEPTH (MAX_SLOTS)
   ) u_offset_ram (
      .clock   (clock),
      .wr_en   (offset_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (offset_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (offset_rd_data)
   );

   tra_ctrl #(
      .MAX_SLOTS      (MAX_SLOTS),
      .REGISTER_SLOTS (REGISTER_SLOTS),
      .ID_BITS        (ID_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .owner_rd_data  (owner_rd_data),
      .offset_rd_data (offset_rd_data),
      .mem_wr_addr    (mem_wr_addr),
      .owner_wr_en    (owner_wr_en),
      .owner_wr_data  (owner_wr_data),
      .offset_wr_en   (offset_wr_en),
      .offset_wr_data (offset_wr_data)
   );

   // a grown frame slot is a stack slot below the frame base
   `ASSERT_IMPLY(a_grow_is_stack, clock, reset, rsp_bus.valid && rsp_bus.payload.grew_stack, !rsp_bus.payload.in_register && rsp_bus.payload.slot_bytes != 4'd0 && rsp_bus.payload.frame_offset[15], "grown slot is not a stack slot")

   `ASSERT_IMPLY(a_reg_slot_clean, clock, reset, rsp_bus.valid && rsp_bus.payload.in_register, rsp_bus.payload.slot_bytes == 4'd0 && rsp_bus.payload.frame_offset == 16'sd0 && int'(rsp_bus.payload.register_index) < REGISTER_SLOTS, "register slot carries stack fields")

   `ASSERT_IMPLY(a_fail_no_slot, clock, reset, rsp_bus.valid && rsp_bus.payload.status != tra_pkg::STATUS_DONE, !rsp_bus.payload.in_register && !rsp_bus.payload.grew_stack && rsp_bus.payload.slot_bytes == 4'd0, "failed beat reports a slot")

   // sequencer is busy in the cycle after it takes a beat
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready, "req taken while previous beat still in work")
endmodule

/* design/tra_ram.sv */
// ----------------------------------------------------------------------------
// tra_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tra_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* design/tra_ctrl.sv */
// ----------------------------------------------------------------------------
// tra_ctrl
// sequencer: scans the owner table through the rams, claims, frees or appends slots
// ----------------------------------------------------------------------------
module tra_ctrl #(
   parameter int MAX_SLOTS      = 32,
   parameter int REGISTER_SLOTS = 5,
   parameter int ID_BITS        = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   tra_chan_if.sink                      req_bus,
   tra_chan_if.source                    rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [3:0]                    csr_wr_data,
   output logic                          mem_rd_en,
   output logic [$clog2(MAX_SLOTS)-1:0]  mem_rd_addr,
   input  logic [ID_BITS-1:0]            owner_rd_data,
   input  logic [15:0]                   offset_rd_data,
   output logic [$clog2(MAX_SLOTS)-1:0]  mem_wr_addr,
   output logic                          owner_wr_en,
   output logic [ID_BITS-1:0]            owner_wr_data,
   output logic                          offset_wr_en,
   output logic [15:0]                   offset_wr_data
);
   localparam int SlotW = $clog2(MAX_SLOTS);
   localparam int CntW  = $clog2(MAX_SLOTS + 1);
   localparam int ExtW  = (ID_BITS > 16) ? ID_BITS : 16;

   tra_pkg::state_type       state_ff, state_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic [ID_BITS-1:0]       id_ff, id_in;
   logic [SlotW-1:0]         idx_ff, idx_in;
   logic                     free_found_ff, free_found_in;
   logic [SlotW-1:0]         free_idx_ff, free_idx_in;
   logic signed [15:0]       free_off_ff, free_off_in;
   logic [CntW-1:0]          used_ff, used_in;
   logic signed [15:0]       lowest_ff, lowest_in;
   logic [3:0]               wbytes_ff;
   logic [MAX_SLOTS-1:0]     valid_ff, valid_in;
   tra_pkg::rsp_payload_type res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   tra_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [ExtW-1:0]    id_ext;
   logic [ID_BITS-1:0] id_new;
   logic               start_scan;
   logic [ID_BITS-1:0] entry;
   logic               entry_match;
   logic               entry_free;
   logic               scan_last;
   logic [3:0]         slot_size;
   logic [16:0]        next_wide;
   logic               grow_blocked;
   logic               rsp_load;

   function automatic tra_pkg::rsp_payload_type emit_slot(
      input logic [SlotW-1:0]  slot,
      input logic signed [15:0] off,
      input logic [3:0]         bytes
   );
      tra_pkg::rsp_payload_type r;
      r = '0;
      if (int'(slot) < REGISTER_SLOTS) begin
         r.in_register    = 1'b1;
         r.register_index = slot[2:0];
      end else begin
         r.frame_offset = off;
         r.slot_bytes   = bytes;
      end
      return r;
   endfunction

   assign id_ext     = ExtW'(req_bus.payload.temp_id);
   assign id_new     = id_ext[ID_BITS-1:0];
   assign start_scan = ((req_bus.payload.command == tra_pkg::CMD_ACQUIRE) ||
                        (req_bus.payload.command == tra_pkg::CMD_RELEASE)) &&
                       (id_new != '0);

   // entries not written since restart read as free
   assign entry       = valid_ff[idx_ff] ? owner_rd_data : '0;
   assign entry_match = (entry == id_ff);
   assign entry_free  = (entry == '0);
   assign scan_last   = ((CntW'(idx_ff) + CntW'(1)) == used_ff);

   assign slot_size    = (wbytes_ff == tra_pkg::WIDE_WORD_BYTES) ?
                         tra_pkg::WIDE_WORD_BYTES : tra_pkg::NARROW_WORD_BYTES;
   assign next_wide    = {lowest_ff[15], lowest_ff} - {13'd0, slot_size};
   assign grow_blocked = (used_ff == CntW'(MAX_SLOTS)) || (next_wide[16] != next_wide[15]);

   assign rsp_load = (state_ff == tra_pkg::ST_REPLY) && (!rsp_valid_ff || rsp_bus.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tra_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = start_scan ? tra_pkg::ST_READ : tra_pkg::ST_REPLY;
            end
         end
         tra_pkg::ST_READ: begin
            state_in = tra_pkg::ST_CHECK;
         end
         tra_pkg::ST_CHECK: begin
            priority if (entry_match) begin
               state_in = tra_pkg::ST_REPLY;
            end else if (scan_last) begin
               state_in = tra_pkg::ST_FINISH;
            end else begin
               state_in = tra_pkg::ST_READ;
            end
         end
         tra_pkg::ST_FINISH: begin
            state_in = tra_pkg::ST_REPLY;
         end
         tra_pkg::ST_REPLY: begin
            if (rsp_load) begin
               state_in = tra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tra_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      cmd_in         = cmd_ff;
      id_in          = id_ff;
      idx_in         = idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      free_off_in    = free_off_ff;
      used_in        = used_ff;
      lowest_in      = lowest_ff;
      valid_in       = valid_ff;
      res_in         = res_ff;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = idx_ff;
      mem_wr_addr    = free_idx_ff;
      owner_wr_en    = 1'b0;
      owner_wr_data  = id_ff;
      offset_wr_en   = 1'b0;
      offset_wr_data = next_wide[15:0];

      unique case (state_ff)
         tra_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               cmd_in        = req_bus.payload.command;
               id_in         = id_new;
               idx_in        = '0;
               free_found_in = 1'b0;
               res_in        = '0;
               unique case (req_bus.payload.command)
                  tra_pkg::CMD_ACQUIRE: begin
                  end
                  tra_pkg::CMD_RELEASE: begin
                     res_in.status = tra_pkg::STATUS_NOT_HELD;
                  end
                  tra_pkg::CMD_NOTE: begin
                     if (req_bus.payload.local_offset < lowest_ff) begin
                        lowest_in = req_bus.payload.local_offset;
                     end
                  end
                  tra_pkg::CMD_RESTART: begin
                     valid_in  = '0;
                     used_in   = CntW'(REGISTER_SLOTS);
                     lowest_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tra_pkg::ST_READ: begin
            mem_rd_en = 1'b1;
         end
         tra_pkg::ST_CHECK: begin
            priority if (entry_match) begin
               if (cmd_ff == tra_pkg::CMD_ACQUIRE) begin
                  res_in = emit_slot(idx_ff, offset_rd_data, slot_size);
               end else begin
                  valid_in[idx_ff] = 1'b0;
                  res_in.status    = tra_pkg::STATUS_DONE;
               end
            end else begin
               if (entry_free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
                  free_off_in   = offset_rd_data;
               end
               if (!scan_last) begin
                  idx_in = idx_ff + SlotW'(1);
               end
            end
         end
         tra_pkg::ST_FINISH: begin
            if (cmd_ff == tra_pkg::CMD_ACQUIRE) begin
               priority if (free_found_ff) begin
                  owner_wr_en           = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
                  res_in = emit_slot(free_idx_ff, free_off_ff, slot_size);
               end else if (grow_blocked) begin
                  res_in.status = tra_pkg::STATUS_FULL;
               end else begin
                  mem_wr_addr                      = used_ff[SlotW-1:0];
                  owner_wr_en                      = 1'b1;
                  offset_wr_en                     = 1'b1;
                  valid_in[used_ff[SlotW-1:0]]     = 1'b1;
                  used_in                          = used_ff + CntW'(1);
                  lowest_in                        = next_wide[15:0];
                  res_in = emit_slot(used_ff[SlotW-1:0], next_wide[15:0], slot_size);
                  res_in.grew_stack                = 1'b1;
               end
            end
         end
         tra_pkg::ST_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   // output register frees the sequencer while a result waits
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tra_pkg::ST_IDLE;
         used_ff       <= CntW'(REGISTER_SLOTS);
         lowest_ff     <= '0;
         wbytes_ff     <= tra_pkg::NARROW_WORD_BYTES;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         lowest_ff     <= lowest_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_found_ff <= free_found_in;
         if (csr_wr_en) begin
            wbytes_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      idx_ff      <= idx_in;
      free_idx_ff <= free_idx_in;
      free_off_ff <= free_off_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_bus.ready   = (state_ff == tra_pkg::ST_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;
endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// temp register spill allocator: a short table of directed requests, then
// random acquire / release / note / restart traffic over several word sizes,
// with every response checked against its table row or an in-bench slot table model
// ----------------------------------------------------------------------------
module testbench;
   import tra_pkg::*;

   localparam int SLOT_COUNT   = 32;
   localparam int REG_SLOTS    = 5;
   localparam int OFFSET_FLOOR = -32768;
   localparam int PHASE_COUNT  = 6;
   localparam int PHASE_ITEMS  = 242;
   localparam int POOL_SIZE    = 40;
   localparam int SETTLE_CYCLES = 70;

   localparam rsp_payload_type RSP_DONE     = '{1'b0, 3'd0, 16'sd0, 4'd0, 1'b0, STATUS_DONE};
   localparam rsp_payload_type RSP_FULL     = '{1'b0, 3'd0, 16'sd0, 4'd0, 1'b0, STATUS_FULL};
   localparam rsp_payload_type RSP_NOT_HELD =
      '{1'b0, 3'd0, 16'sd0, 4'd0, 1'b0, STATUS_NOT_HELD};

   typedef struct {
      req_payload_type req;
      bit              known;
      rsp_payload_type rsp;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 23;

   // word size is 4 bytes out of reset
   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{'{CMD_ACQUIRE, 16'h0000, 16'sh0000}, 1'b1, RSP_DONE},
      '{'{CMD_RELEASE, 16'h0000, 16'sh7fff}, 1'b1, RSP_NOT_HELD},
      '{'{CMD_RELEASE, 16'hffff, 16'sh8000}, 1'b1, RSP_NOT_HELD},
      '{'{CMD_ACQUIRE, 16'h0001, 16'sh0000}, 1'b1,
        '{1'b1, 3'd0, 16'sd0, 4'd0, 1'b0, STATUS_DONE}},
      '{'{CMD_ACQUIRE, 16'hffff, 16'shffff}, 1'b1,
        '{1'b1, 3'd1, 16'sd0, 4'd0, 1'b0, STATUS_DONE}},
      '{'{CMD_ACQUIRE, 16'h0001, 16'sh0000}, 1'b1,
        '{1'b1, 3'd0, 16'sd0, 4'd0, 1'b0, STATUS_DONE}},
      '{'{CMD_ACQUIRE, 16'h0003, 16'sh0000}, 1'b0, RSP_DONE},
      '{'{CMD_ACQUIRE, 16'h0004, 16'sh0000}, 1'b0, RSP_DONE},
      '{'{CMD_ACQUIRE, 16'h0005, 16'sh0000}, 1'b0, RSP_DONE},
      '{'{CMD_ACQUIRE, 16'h0006, 16'sh0000}, 1'b1,
        '{1'b0, 3'd0, -16'sd4, 4'd4, 1'b1, STATUS_DONE}},
      '{'{CMD_NOTE,    16'h0000, 16'sh7fff}, 1'b1, RSP_DONE},
      '{'{CMD_NOTE,    16'hffff, -16'sd100}, 1'b1, RSP_DONE},
      '{'{CMD_ACQUIRE, 16'h0007, 16'sh0000}, 1'b0, RSP_DONE},
      '{'{CMD_RELEASE, 16'hffff, 16'sh0000}, 1'b1, RSP_DONE},
      '{'{CMD_ACQUIRE, 16'h0008, 16'sh0000}, 1'b0, RSP_DONE},
      '{'{CMD_RELEASE, 16'h0006, 16'sh0000}, 1'b0, RSP_DONE},
      '{'{CMD_ACQUIRE, 16'h0009, 16'sh0000}, 1'b0, RSP_DONE},
      '{'{CMD_NOTE,    16'h0000, 16'sh8000}, 1'b1, RSP_DONE},
      // frame cannot grow past the most negative offset
      '{'{CMD_ACQUIRE, 16'h000a, 16'sh0000}, 1'b1, RSP_FULL},
      '{'{CMD_RELEASE, 16'h8000, 16'sh0000}, 1'b1, RSP_NOT_HELD},
      '{'{CMD_RESTART, 16'hffff, 16'shffff}, 1'b1, RSP_DONE},
      '{'{CMD_ACQUIRE, 16'h8000, 16'sh0000}, 1'b0, RSP_DONE},
      '{'{CMD_ACQUIRE, 16'h7fff, 16'shffff}, 1'b0, RSP_DONE}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [3:0] csr_wr_data;

   tra_chan_if #(.payload_type(req_payload_type)) req_bus ();
   tra_chan_if #(.payload_type(rsp_payload_type)) rsp_bus ();

   temp_register_spill_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // slot table model
   logic [15:0] owner_id [SLOT_COUNT];
   int          spill_offset [SLOT_COUNT];
   int          used_slots;
   int          frame_floor;
   logic [3:0]  word_size;

   rsp_payload_type expected_rsps [$];
   logic [15:0]     id_pool [POOL_SIZE];
   bit              quiet;
   int              errors;
   int              beats_sent;
   int              beats_checked;
   int              grew_count;
   int              full_count;
   int              miss_count;
   int              stall_left;

   function automatic rsp_payload_type apply_command(input req_payload_type p);
      rsp_payload_type r;
      int              hit;
      int              next_floor;
      int              step;
      r    = '0;
      hit  = -1;
      step = (word_size == WIDE_WORD_BYTES) ? 8 : 4;
      case (p.command)
         CMD_ACQUIRE: begin
            if (p.temp_id != 16'd0) begin
               for (int i = 0; i < used_slots; i++)
                  if (hit < 0 && owner_id[i] == p.temp_id) hit = i;
               if (hit < 0) begin
                  for (int i = 0; i < used_slots; i++)
                     if (hit < 0 && owner_id[i] == 16'd0) begin
                        hit = i;
                        owner_id[i] = p.temp_id;
                     end
               end
               if (hit < 0) begin
                  next_floor = frame_floor - step;
                  if (used_slots >= SLOT_COUNT || next_floor < OFFSET_FLOOR) begin
                     r.status = STATUS_FULL;
                  end else begin
                     hit = used_slots;
                     frame_floor = next_floor;
                     spill_offset[hit] = next_floor;
                     owner_id[hit] = p.temp_id;
                     used_slots++;
                     r.grew_stack = 1'b1;
                  end
               end
               if (hit >= 0 && hit < REG_SLOTS) begin
                  r.in_register    = 1'b1;
                  r.register_index = hit[2:0];
               end else if (hit >= 0) begin
                  r.frame_offset = spill_offset[hit][15:0];
                  r.slot_bytes   = step[3:0];
               end
            end
         end
         CMD_RELEASE: begin
            r.status = STATUS_NOT_HELD;
            if (p.temp_id != 16'd0) begin
               for (int i = 0; i < used_slots; i++)
                  if (r.status == STATUS_NOT_HELD && owner_id[i] == p.temp_id) begin
                     owner_id[i] = 16'd0;
                     r.status = STATUS_DONE;
                  end
            end
         end
         CMD_NOTE: begin
            if (int'(p.local_offset) < frame_floor) frame_floor = int'(p.local_offset);
         end
         default: begin
            foreach (owner_id[i]) owner_id[i] = 16'd0;
            used_slots  = REG_SLOTS;
            frame_floor = 0;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s on result %0d: got %0d, expected %0d",
               what, beats_checked, got, want);
      errors++;
   endtask

   // one request beat; returns right after the accepting edge
   task automatic send_req(input req_payload_type p, input bit known,
                           input rsp_payload_type want);
      rsp_payload_type model;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      model = apply_command(p);
      expected_rsps.push_back(known ? want : model);
      beats_sent++;
   endtask

   task automatic set_word_size(input logic [3:0] value);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      word_size = value;
   endtask

   // response side stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(1, 19) - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         if (expected_rsps.size() == 0) begin
            report_mismatch("beat with nothing outstanding", got.status, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (got.in_register !== want.in_register)
               report_mismatch("in_register", got.in_register, want.in_register);
            if (got.register_index !== want.register_index)
               report_mismatch("register_index", got.register_index, want.register_index);
            if (got.frame_offset !== want.frame_offset)
               report_mismatch("frame_offset", got.frame_offset, want.frame_offset);
            if (got.slot_bytes !== want.slot_bytes)
               report_mismatch("slot_bytes", got.slot_bytes, want.slot_bytes);
            if (got.grew_stack !== want.grew_stack)
               report_mismatch("grew_stack", got.grew_stack, want.grew_stack);
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            grew_count += want.grew_stack;
            full_count += (want.status == STATUS_FULL);
            miss_count += (want.status == STATUS_NOT_HELD);
         end
         beats_checked++;
      end
   end

   initial begin
      req_payload_type p;
      logic [3:0]      sizes [PHASE_COUNT];
      int              roll;
      int              acquire_edge;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = 4'd0;
      quiet           = 1'b0;
      foreach (owner_id[i]) begin
         owner_id[i]     = 16'd0;
         spill_offset[i] = 0;
      end
      used_slots  = REG_SLOTS;
      frame_floor = 0;
      word_size   = NARROW_WORD_BYTES;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_req(directed_rows[i].req, directed_rows[i].known, directed_rows[i].rsp);

      // twenty small ids plus twenty random ones, so the table fills and ids repeat
      foreach (id_pool[i])
         id_pool[i] = (i < 20) ? 16'(i + 1) : 16'($urandom_range(1, 65535));

      sizes = '{WIDE_WORD_BYTES, 4'd0, 4'd15, 4'($urandom_range(0, 15)),
                NARROW_WORD_BYTES, WIDE_WORD_BYTES};

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         set_word_size(sizes[phase]);
         if (phase == PHASE_COUNT - 1) quiet = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // acquire-heavy first half fills the table, second half drains it
            acquire_edge = (k < PHASE_ITEMS / 2) ? 72 : 40;
            roll = $urandom_range(0, 99);
            p.temp_id      = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            p.local_offset = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 19) == 0) p.temp_id = 16'($urandom_range(0, 65535));
            if (roll < 2) begin
               p.command = CMD_RESTART;
            end else if (roll < 6) begin
               p.command = CMD_NOTE;
               case ($urandom_range(0, 9))
                  0: ;
                  1: p.local_offset = 16'(OFFSET_FLOOR + int'($urandom_range(0, 16)));
                  default: p.local_offset = 16'(0 - int'($urandom_range(0, 300)));
               endcase
            end else if (roll < acquire_edge) begin
               p.command = CMD_ACQUIRE;
            end else begin
               p.command = CMD_RELEASE;
            end
            send_req(p, 1'b0, RSP_DONE);
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d responses checked over %0d word-size settings",
               beats_sent, beats_checked, PHASE_COUNT + 1);
      $display("frame growths %0d, table-full replies %0d, release misses %0d",
               grew_count, full_count, miss_count);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
